FILE: src/tlbr_pkg.sv
package tlbr_pkg;

    localparam int DEF_ENTRIES    = 32;
    localparam int DEF_PAGE_BITS  = 16;
    localparam int DEF_FRAME_BITS = 16;

    localparam int              LFSR_BITS = 16;
    localparam logic [15:0]     LFSR_TAPS = 16'hB400;
    localparam int              CFG_DATA_BITS = 16;
    localparam int              CFG_IDX_BITS  = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_POLICY = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEED   = 1'b1;

    localparam logic POLICY_LRU    = 1'b0;
    localparam logic POLICY_RANDOM = 1'b1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_FILL   = 2'd1,
        OP_INVAL  = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_SELECT,
        ST_COMMIT
    } state_t;

    // per-cell update command, applied when an item commits
    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } cell_ctl_t;

    function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] v);
        logic [LFSR_BITS-1:0] r;
        r = v >> 1;
        if (v[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

FILE: src/tlbr_cell.sv
module tlbr_cell
    import tlbr_pkg::*;
#(
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int FRAME_BITS = DEF_FRAME_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctl_t             ctl,
    input  logic [PAGE_BITS-1:0]  cmp_page,
    input  logic [PAGE_BITS-1:0]  bus_page,
    input  logic [FRAME_BITS-1:0] bus_frame,
    input  logic                  prev_valid,
    input  logic [PAGE_BITS-1:0]  prev_page,
    input  logic [FRAME_BITS-1:0] prev_frame,
    output logic                  valid,
    output logic [PAGE_BITS-1:0]  page_q,
    output logic [FRAME_BITS-1:0] frame_q,
    output logic                  match
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [PAGE_BITS-1:0]  page_next;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;

    always_comb
    begin
        valid_next = valid_reg;
        page_next  = page_reg;
        frame_next = frame_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.load)
        begin
            valid_next = 1'b1;
            page_next  = bus_page;
            frame_next = bus_frame;
        end
        else if (ctl.shift)
        begin
            valid_next = prev_valid;
            page_next  = prev_page;
            frame_next = prev_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        frame_reg <= frame_next;
    end

    assign valid   = valid_reg;
    assign page_q  = page_reg;
    assign frame_q = frame_reg;
    assign match   = valid_reg && (page_reg == cmp_page);

endmodule

FILE: src/tlbr_rmod.sv
module tlbr_rmod
    import tlbr_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [LFSR_BITS-1:0]       operand,
    output logic                       busy,
    output logic [$clog2(ENTRIES)-1:0] pick
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int MW    = LFSR_BITS + 1;
    localparam int PRODW = LFSR_BITS + MW;
    localparam int SH    = LFSR_BITS + IW;
    // 2^SH / ENTRIES rounded up gives the exact quotient for every operand value
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));
    localparam logic [LFSR_BITS-1:0] DIVISOR = LFSR_BITS'(ENTRIES);

    logic                 busy_reg;
    logic                 busy_next;
    logic [LFSR_BITS-1:0] quot_reg;
    logic [LFSR_BITS-1:0] quot_next;
    logic [IW-1:0]        pick_reg;
    logic [IW-1:0]        pick_next;
    logic [PRODW-1:0]     prod;
    logic [LFSR_BITS-1:0] rem_full;

    // quotient by reciprocal multiply in the start cycle, remainder in the next
    always_comb
    begin
        prod     = PRODW'(operand) * PRODW'(RECIP);
        rem_full = operand - LFSR_BITS'(quot_reg * DIVISOR);
    end

    always_comb
    begin
        busy_next = 1'b0;
        quot_next = quot_reg;
        pick_next = pick_reg;
        if (start)
        begin
            busy_next = 1'b1;
            quot_next = LFSR_BITS'(prod >> SH);
        end
        else if (busy_reg)
        begin
            pick_next = rem_full[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        pick_reg <= pick_next;
    end

    assign busy = busy_reg;
    assign pick = pick_reg;

endmodule

FILE: src/tlb_lru_random_replace_top.sv
// Fully associative translation buffer of ENTRIES slots, kept as a row of cells, in recency
// order under the LRU policy (front = most recent). Every item returns one result. An item
// is compared against all cells, then the target and victim are picked, then the row update
// is committed and the output register loaded; no new item is taken until it is through.
// The commit waits while a previous result is still held under stall. After reset, a seed
// write or a random replacement with a full buffer, the remainder unit that reduces the next
// pseudo-random value modulo ENTRIES by a reciprocal multiply holds off new items until it
// is done. There is no clearing pass after reset; the valid bits clear at once.
module tlb_lru_random_replace_top
    import tlbr_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int FRAME_BITS = DEF_FRAME_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               opcode,
    input  logic [PAGE_BITS-1:0]     page,
    input  logic [FRAME_BITS-1:0]    frame,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     hit,
    output logic [FRAME_BITS-1:0]    frame_out,
    output logic                     evicted_valid,
    output logic [PAGE_BITS-1:0]     evicted_page
);

    localparam int IW = $clog2(ENTRIES);

    function automatic logic [ENTRIES-1:0] prefix_or(input logic [ENTRIES-1:0] v);
        logic [ENTRIES-1:0] x;
        x = v;
        for (int d = 1; d < ENTRIES; d = d * 2)
        begin
            x = x | (x << d);
        end
        return x;
    endfunction

    // control
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   commit_go;
    logic   policy_reg;
    logic   policy_next;
    logic [LFSR_BITS-1:0] lfsr_reg;
    logic [LFSR_BITS-1:0] lfsr_next;
    logic   restart_reg;
    logic   restart_next;
    logic   seed_we;
    logic   mod_busy;
    logic [IW-1:0] pick;

    // captured item
    op_t                   op_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FRAME_BITS-1:0] frame_reg;

    // compare stage
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] free_reg;

    // select stage
    logic [ENTRIES-1:0]    tgt_reg;
    logic [ENTRIES-1:0]    thermo_reg;
    logic [FRAME_BITS-1:0] bus_frame_reg;
    logic                  res_hit_reg;
    logic [FRAME_BITS-1:0] res_frame_reg;
    logic                  res_ev_reg;
    logic [PAGE_BITS-1:0]  res_evpage_reg;
    logic                  step_reg;

    logic [ENTRIES-1:0]    hit_pre;
    logic [ENTRIES-1:0]    hit_oh;
    logic [ENTRIES-1:0]    free_pre;
    logic [ENTRIES-1:0]    free_oh;
    logic [ENTRIES-1:0]    victim_oh;
    logic [ENTRIES-1:0]    tgt_oh;
    logic [FRAME_BITS-1:0] hit_frame;
    logic [PAGE_BITS-1:0]  tgt_page;
    logic                  any_hit;
    logic                  any_free;
    logic                  is_lookup;
    logic                  is_fill;
    logic                  lru;
    logic                  full;
    logic                  move;
    logic                  inplace;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  hit_out_reg;
    logic [FRAME_BITS-1:0] frame_out_reg;
    logic                  ev_out_reg;
    logic [PAGE_BITS-1:0]  evpage_out_reg;

    // cell row
    cell_ctl_t             ctl [ENTRIES];
    logic                  cell_valid [ENTRIES];
    logic [PAGE_BITS-1:0]  cell_page  [ENTRIES];
    logic [FRAME_BITS-1:0] cell_frame [ENTRIES];
    logic [ENTRIES-1:0]    cell_match;
    logic [ENTRIES-1:0]    cell_free;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                tlbr_cell #(
                    .PAGE_BITS  (PAGE_BITS),
                    .FRAME_BITS (FRAME_BITS)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl[g]),
                    .cmp_page   (page_reg),
                    .bus_page   (page_reg),
                    .bus_frame  (bus_frame_reg),
                    .prev_valid (1'b0),
                    .prev_page  ({PAGE_BITS{1'b0}}),
                    .prev_frame ({FRAME_BITS{1'b0}}),
                    .valid      (cell_valid[g]),
                    .page_q     (cell_page[g]),
                    .frame_q    (cell_frame[g]),
                    .match      (cell_match[g])
                );
            end
            else
            begin : g_body
                tlbr_cell #(
                    .PAGE_BITS  (PAGE_BITS),
                    .FRAME_BITS (FRAME_BITS)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl[g]),
                    .cmp_page   (page_reg),
                    .bus_page   (page_reg),
                    .bus_frame  (bus_frame_reg),
                    .prev_valid (cell_valid[g-1]),
                    .prev_page  (cell_page[g-1]),
                    .prev_frame (cell_frame[g-1]),
                    .valid      (cell_valid[g]),
                    .page_q     (cell_page[g]),
                    .frame_q    (cell_frame[g]),
                    .match      (cell_match[g])
                );
            end
            assign cell_free[g] = !cell_valid[g];
        end
    endgenerate

    tlbr_rmod #(
        .ENTRIES (ENTRIES)
    ) u_rmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (restart_reg),
        .operand (lfsr_step(lfsr_reg)),
        .busy    (mod_busy),
        .pick    (pick)
    );

    // fsm outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE) || mod_busy || restart_reg;
        accept    = in_valid && !in_stall;
        commit_go = (state_reg == ST_COMMIT) && (!out_valid_reg || !out_stall);
    end

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration and pseudo-random state
    always_comb
    begin
        policy_next  = policy_reg;
        lfsr_next    = lfsr_reg;
        seed_we      = 1'b0;
        restart_next = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLICY:
                begin
                    policy_next = cfg_data[0];
                end
                REG_SEED:
                begin
                    seed_we = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (seed_we)
        begin
            // a zero seed would lock the generator
            lfsr_next    = (cfg_data == '0) ? LFSR_BITS'(1) : cfg_data;
            restart_next = 1'b1;
        end
        else if (commit_go && step_reg)
        begin
            lfsr_next    = lfsr_step(lfsr_reg);
            restart_next = 1'b1;
        end
    end

    // select stage logic
    always_comb
    begin
        lru       = (policy_reg == POLICY_LRU);
        is_lookup = (op_reg == OP_LOOKUP);
        is_fill   = (op_reg == OP_FILL);
        hit_pre   = prefix_or(match_reg);
        free_pre  = prefix_or(free_reg);
        hit_oh    = match_reg & ~(hit_pre << 1);
        free_oh   = free_reg & ~(free_pre << 1);
        any_hit   = hit_pre[ENTRIES-1];
        any_free  = free_pre[ENTRIES-1];
        victim_oh = '0;
        for (int p = 0; p < ENTRIES; p++)
        begin
            if (lru)
            begin
                victim_oh[p] = (p == ENTRIES - 1);
            end
            else
            begin
                victim_oh[p] = (pick == IW'(p));
            end
        end
        if (is_lookup)
        begin
            tgt_oh = hit_oh;
        end
        else if (is_fill)
        begin
            tgt_oh = any_free ? free_oh : victim_oh;
        end
        else
        begin
            tgt_oh = '0;
        end
        hit_frame = '0;
        tgt_page  = '0;
        for (int p = 0; p < ENTRIES; p++)
        begin
            hit_frame = hit_frame | (cell_frame[p] & {FRAME_BITS{hit_oh[p]}});
            tgt_page  = tgt_page | (cell_page[p] & {PAGE_BITS{tgt_oh[p]}});
        end
        full = is_fill && !any_free;
    end

    // commit commands for the row
    always_comb
    begin
        move    = lru && (is_lookup ? res_hit_reg : is_fill);
        inplace = !lru && is_fill;
        for (int p = 0; p < ENTRIES; p++)
        begin
            ctl[p].load  = commit_go && (move ? (p == 0) : (inplace && tgt_reg[p]));
            ctl[p].shift = commit_go && move && thermo_reg[p] && (p != 0);
            ctl[p].clear = commit_go && (((op_reg == OP_INVAL) && match_reg[p])
                                         || (op_reg == OP_FLUSH));
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            policy_reg    <= POLICY_LRU;
            lfsr_reg      <= LFSR_BITS'(1);
            restart_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            lfsr_reg      <= lfsr_next;
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(opcode);
            page_reg  <= page;
            frame_reg <= frame;
        end
        if (state_reg == ST_COMPARE)
        begin
            match_reg <= cell_match;
            free_reg  <= cell_free;
        end
        if (state_reg == ST_SELECT)
        begin
            tgt_reg        <= tgt_oh;
            // positions from the front up to and including the target
            thermo_reg     <= ~(prefix_or(tgt_oh) << 1);
            bus_frame_reg  <= is_lookup ? hit_frame : frame_reg;
            res_hit_reg    <= is_lookup && any_hit;
            res_frame_reg  <= is_lookup ? hit_frame : '0;
            res_ev_reg     <= full;
            res_evpage_reg <= full ? tgt_page : '0;
            step_reg       <= full && !lru;
        end
        if (commit_go)
        begin
            hit_out_reg    <= res_hit_reg;
            frame_out_reg  <= res_frame_reg;
            ev_out_reg     <= res_ev_reg;
            evpage_out_reg <= res_evpage_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_out_reg;
    assign frame_out     = frame_out_reg;
    assign evicted_valid = ev_out_reg;
    assign evicted_page  = evpage_out_reg;

endmodule

FILE: src/tlbr_checker.sv
module tlbr_checker
    import tlbr_pkg::*;
#(
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int FRAME_BITS = DEF_FRAME_BITS
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  hit,
    input logic [FRAME_BITS-1:0] frame_out,
    input logic                  evicted_valid,
    input logic [PAGE_BITS-1:0]  evicted_page
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(frame_out)
            && $stable(evicted_valid) && $stable(evicted_page))
        else $error("result changed while stalled");

    // a lookup hit and an eviction never come from the same item
    a_hit_or_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted_valid))
        else $error("hit and eviction in one result");

    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> frame_out == '0)
        else $error("frame without hit");

    a_evpage_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_page == '0)
        else $error("evicted page without eviction");

    // the block is busy after taking an item, so it never takes items back to back
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item taken on consecutive cycles");

endmodule

bind tlb_lru_random_replace_top tlbr_checker #(
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
) u_tlbr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .frame_out     (frame_out),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page)
);

FILE: sim/tlb_lru_random_replace_top_test.sv
module tlb_lru_random_replace_top_test;
    import tlbr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS   = DEF_ENTRIES;
    localparam int PW      = DEF_PAGE_BITS;
    localparam int FW      = DEF_FRAME_BITS;
    localparam int POOL    = 48;
    localparam int SETTLE  = 24;

    typedef struct packed {
        logic          hit;
        logic [FW-1:0] frame_out;
        logic          evicted_valid;
        logic [PW-1:0] evicted_page;
    } xlate_result_t;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = REG_POLICY;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [1:0]               opcode    = OP_LOOKUP;
    logic [PW-1:0]            page      = '0;
    logic [FW-1:0]            frame     = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     hit;
    logic [FW-1:0]            frame_out;
    logic                     evicted_valid;
    logic [PW-1:0]            evicted_page;

    // shadow copy of the buffer
    logic                     slot_valid [SLOTS];
    logic [PW-1:0]            slot_page  [SLOTS];
    logic [FW-1:0]            slot_frame [SLOTS];
    int                       recency    [SLOTS];
    logic [15:0]              prng;
    logic                     policy_random;

    xlate_result_t            xlate_q[$];
    logic [PW-1:0]            page_pool [POOL];
    int                       fail_count = 0;
    bit                       quiet      = 1'b0;
    int                       long_hold  = 0;

    tlb_lru_random_replace_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .page          (page),
        .frame         (frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_out     (frame_out),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void shadow_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_page[i]  = '0;
            slot_frame[i] = '0;
            recency[i]    = i;
        end
        policy_random = POLICY_LRU;
        prng          = 16'd1;
    endfunction

    function automatic void move_to_front(int pos);
        int s;
        s = recency[pos];
        for (int k = pos; k > 0; k--)
        begin
            recency[k] = recency[k-1];
        end
        recency[0] = s;
    endfunction

    function automatic xlate_result_t translate_and_update(op_t op, logic [PW-1:0] pg,
                                                           logic [FW-1:0] fr);
        xlate_result_t res;
        bit            found;
        int            pos;
        int            s;
        res   = '0;
        found = 1'b0;
        case (op)
            OP_LOOKUP:
            begin
                for (pos = 0; pos < SLOTS && !found; pos++)
                begin
                    s = recency[pos];
                    if (slot_valid[s] && slot_page[s] == pg)
                    begin
                        found         = 1'b1;
                        res.hit       = 1'b1;
                        res.frame_out = slot_frame[s];
                        if (policy_random == POLICY_LRU)
                            move_to_front(pos);
                    end
                end
            end
            OP_FILL:
            begin
                for (pos = 0; pos < SLOTS && !found; pos++)
                begin
                    s = recency[pos];
                    if (!slot_valid[s])
                    begin
                        found         = 1'b1;
                        slot_valid[s] = 1'b1;
                        slot_page[s]  = pg;
                        slot_frame[s] = fr;
                        if (policy_random == POLICY_LRU)
                            move_to_front(pos);
                    end
                end
                if (!found)
                begin
                    if (policy_random == POLICY_RANDOM)
                    begin
                        // galois step, then the new value picks the list position
                        prng = (prng >> 1) ^ (prng[0] ? LFSR_TAPS : 16'h0000);
                        pos  = int'(prng) % SLOTS;
                    end
                    else
                    begin
                        pos = SLOTS - 1;
                    end
                    s                 = recency[pos];
                    res.evicted_valid = 1'b1;
                    res.evicted_page  = slot_page[s];
                    slot_page[s]      = pg;
                    slot_frame[s]     = fr;
                    if (policy_random == POLICY_LRU)
                        move_to_front(pos);
                end
            end
            OP_INVAL:
            begin
                for (s = 0; s < SLOTS; s++)
                begin
                    if (slot_valid[s] && slot_page[s] == pg)
                        slot_valid[s] = 1'b0;
                end
            end
            default:
            begin
                // recency order is left alone by a flush
                for (s = 0; s < SLOTS; s++)
                begin
                    slot_valid[s] = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    // result side: random stall bursts, plus a long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                n         = long_hold;
                long_hold = 0;
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        xlate_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (xlate_q.size() == 0)
            begin
                $error("result item with nothing outstanding");
                fail_count++;
            end
            else
            begin
                want = xlate_q.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    fail_count++;
                end
                if (frame_out !== want.frame_out)
                begin
                    $error("frame_out: expected %h, got %h", want.frame_out, frame_out);
                    fail_count++;
                end
                if (evicted_valid !== want.evicted_valid)
                begin
                    $error("evicted_valid: expected %0d, got %0d", want.evicted_valid,
                           evicted_valid);
                    fail_count++;
                end
                if (evicted_page !== want.evicted_page)
                begin
                    $error("evicted_page: expected %h, got %h", want.evicted_page,
                           evicted_page);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_item(op_t op, logic [PW-1:0] pg, logic [FW-1:0] fr);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        page     <= pg;
        frame    <= fr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        xlate_q.push_back(translate_and_update(op, pg, fr));
    endtask

    // mostly pages from a small working set so that hits and duplicates happen
    task automatic send_random_item();
        int            r;
        op_t           op;
        logic [PW-1:0] pg;
        r = $urandom_range(0, 99);
        if (r < 44)
            op = OP_LOOKUP;
        else if (r < 91)
            op = OP_FILL;
        else if (r < 99)
            op = OP_INVAL;
        else
            op = OP_FLUSH;
        if ($urandom_range(0, 9) < 8)
            pg = page_pool[$urandom_range(0, POOL - 1)];
        else
            pg = PW'($urandom);
        send_item(op, pg, FW'($urandom));
    endtask

    task automatic refresh_pool();
        for (int i = 0; i < POOL; i++)
        begin
            page_pool[i] = PW'($urandom);
        end
    endtask

    task automatic fill_burst(int n);
        for (int i = 0; i < n; i++)
        begin
            send_item(OP_FILL, page_pool[$urandom_range(0, POOL - 1)], FW'($urandom));
        end
    endtask

    task automatic random_items(int n);
        for (int i = 0; i < n; i++)
        begin
            send_random_item();
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (xlate_q.size() != 0)
            @(negedge clk);
    endtask

    // remainder unit may still be busy after the last result
    task automatic go_idle();
        drain();
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_POLICY)
            policy_random = value[0];
        else
            prng = (value == '0) ? 16'd1 : value;
    endtask

    task automatic test_basic_ops();
        send_item(OP_LOOKUP, 16'h0000, 16'hFFFF);
        send_item(OP_INVAL,  16'h1234, 16'h0000);
        send_item(OP_FILL,   16'h0000, 16'hFFFF);
        send_item(OP_FILL,   16'hFFFF, 16'h0000);
        send_item(OP_LOOKUP, 16'h0000, 16'h0000);
        send_item(OP_LOOKUP, 16'hFFFF, 16'h0000);
        // same page twice: lookup takes the first in list order
        send_item(OP_FILL,   16'hFFFF, 16'hA5A5);
        send_item(OP_LOOKUP, 16'hFFFF, 16'h0000);
        send_item(OP_INVAL,  16'hFFFF, 16'hFFFF);
        send_item(OP_LOOKUP, 16'hFFFF, 16'h0000);
        send_item(OP_LOOKUP, 16'h0000, 16'h0000);
        send_item(OP_FLUSH,  16'h0000, 16'h0000);
        send_item(OP_LOOKUP, 16'h0000, 16'h0000);
        send_item(OP_FILL,   16'h5A5A, 16'h5A5A);
        send_item(OP_LOOKUP, 16'h5A5A, 16'hFFFF);
        send_item(OP_FILL,   16'hA5A5, 16'h8001);
        send_item(OP_LOOKUP, 16'hA5A5, 16'h0000);
        send_item(OP_FLUSH,  16'hFFFF, 16'hFFFF);
        send_item(OP_LOOKUP, 16'h5A5A, 16'h0000);
    endtask

    task automatic test_lru_eviction();
        refresh_pool();
        fill_burst(36);
        random_items(100);
        // receiver holds off while the sender keeps offering items
        long_hold = 60;
        random_items(30);
        random_items(130);
    endtask

    task automatic test_random_victim();
        go_idle();
        write_reg(REG_POLICY, CFG_DATA_BITS'(POLICY_RANDOM));
        write_reg(REG_SEED, 16'hFFFF);
        refresh_pool();
        fill_burst(40);
        random_items(100);
        // sender pauses until every result is back
        drain();
        random_items(116);
    endtask

    task automatic test_zero_seed();
        go_idle();
        write_reg(REG_SEED, 16'h0000);
        fill_burst(36);
        random_items(164);
    endtask

    task automatic test_policy_switch();
        go_idle();
        write_reg(REG_POLICY, CFG_DATA_BITS'(POLICY_LRU));
        write_reg(REG_SEED, 16'h8001);
        refresh_pool();
        random_items(200);
    endtask

    task automatic test_back_to_back();
        go_idle();
        quiet = 1'b1;
        write_reg(REG_POLICY, CFG_DATA_BITS'(POLICY_RANDOM));
        write_reg(REG_SEED, CFG_DATA_BITS'($urandom_range(1, 65535)));
        fill_burst(36);
        random_items(164);
    endtask

    initial
    begin
        shadow_reset();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_lru_eviction();
        test_random_victim();
        test_zero_seed();
        test_policy_switch();
        test_back_to_back();

        drain();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && xlate_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: tlb_lru_random_replace_top.f
src/tlbr_pkg.sv
src/tlbr_cell.sv
src/tlbr_rmod.sv
src/tlb_lru_random_replace_top.sv
src/tlbr_checker.sv
sim/tlb_lru_random_replace_top_test.sv
